// File: hdl/dll_pkg.sv
// Package for the doubly linked list block: sizes, operation codes, word types.
// No dependencies.
package dll_pkg;
    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int KIND_W         = 4;
    localparam int WORD_W         = 32;

    typedef enum logic [KIND_W-1:0] {
        OP_FIRST        = 4'd0,
        OP_NEXT         = 4'd1,
        OP_LAST         = 4'd2,
        OP_PREV         = 4'd3,
        OP_PUSH_FRONT   = 4'd4,
        OP_PUSH_BACK    = 4'd5,
        OP_PUSH_CURRENT = 4'd6,
        OP_POP_FRONT    = 4'd7,
        OP_POP_BACK     = 4'd8,
        OP_POP_CURRENT  = 4'd9,
        OP_CLEAR        = 4'd10
    } op_kind_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] item_value;
    } cmd_word_t;

    typedef struct packed {
        logic [WORD_W-1:0] result_value;
        logic              found;
        logic              dropped_full;
    } rsp_word_t;
endpackage

// File: hdl/dll_node_ram.sv
// Node pool memory: value, next link and prev link per entry, one write port
// and one registered read port. Depends on dll_pkg.
module dll_node_ram
    import dll_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int AW = $clog2(CAPACITY),
    localparam int PW = $clog2(CAPACITY + 1),
    localparam int NW = DATA_WIDTH + 2 * PW
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [NW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [NW-1:0] rdata
);
    logic [NW-1:0] mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: hdl/doubly_linked_list_with_cursor_top.sv
// Doubly linked list with a cursor over a pool of CAPACITY nodes.
// The result word is strobed from S_EVAL for first, last, clear,
// dropped pushes, misses and unused codes; next, prev, pushes and pops go on
// through S_FIX1 to S_FIX3 as needed, one node-memory pass per state (read,
// modify, write back through the single read port). busy falls as the strobe
// rises, and the receiver cannot stall.
// Reset clears the pointers and allocator counts; the memories are not cleared.
module doubly_linked_list_with_cursor_top
    import dll_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  cmd_word_t cmd,
    output logic      done,
    output rsp_word_t rsp
);
    localparam int AW = $clog2(CAPACITY);
    localparam int PW = $clog2(CAPACITY + 1);
    localparam int NW = DATA_WIDTH + 2 * PW;
    localparam logic [PW-1:0] NIL = PW'(CAPACITY);

    // A node word is value, next link, prev link.
    typedef struct packed {
        logic [DATA_WIDTH-1:0] val;
        logic [PW-1:0]         nxt;
        logic [PW-1:0]         prv;
    } node_t;

    // S_READ addresses the target node, S_EVAL sees it and decides. S_FIX1
    // writes a new node and reads the first neighbor, S_FIX2 writes that
    // neighbor back and reads the second one, S_FIX3 writes the second one.
    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EVAL, S_FIX1, S_FIX2, S_FIX3
    } state_t;

    // The free stack lives in its own small memory, written on pops and read
    // at the top of stack every cycle so the word is ready for a push.
    logic [AW-1:0] free_mem [CAPACITY];
    logic [AW-1:0] free_top_reg;

    state_t                state_reg, state_next;
    logic [PW-1:0]         head_reg, head_next;
    logic [PW-1:0]         tail_reg, tail_next;
    logic [PW-1:0]         cur_reg, cur_next;
    logic [PW-1:0]         free_cnt_reg, free_cnt_next;
    logic [PW-1:0]         fresh_cnt_reg, fresh_cnt_next;
    op_kind_t              kind_reg, kind_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [PW-1:0]         tgt_reg, tgt_next;     // node that was read
    logic [PW-1:0]         newn_reg, newn_next;   // allocated node
    node_t                 node_reg, node_next;   // word of the allocated node
    rsp_word_t             rsp_reg, rsp_next;
    logic                  done_reg, done_next;
    logic                  mv_reg, mv_next;       // next or prev with a target and a neighbor

    // Pending neighbor link fixes: fix one writes a prev link, fix two a next.
    // A move to next or prev reuses the fix one address for its second read.
    logic          fx1_reg, fx1_next, fx2_reg, fx2_next;
    logic [PW-1:0] fx1_addr_reg, fx1_addr_next, fx1_val_reg, fx1_val_next;
    logic [PW-1:0] fx2_addr_reg, fx2_addr_next, fx2_val_reg, fx2_val_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    node_t         wdata, rdata;
    logic [NW-1:0] rdata_raw;

    dll_node_ram #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata_raw)
    );
    assign rdata = node_t'(rdata_raw);

    logic [PW-1:0] free_idx;
    logic          free_push;
    assign free_idx  = free_cnt_reg - PW'(1);
    assign free_push = state_reg == S_EVAL &&
                       (kind_reg inside {OP_POP_FRONT, OP_POP_BACK, OP_POP_CURRENT}) &&
                       tgt_reg != NIL && free_cnt_reg < NIL;

    always_ff @(posedge clk)
    begin
        free_top_reg <= free_mem[free_idx[AW-1:0]];
        if (free_push)
        begin
            free_mem[free_cnt_reg[AW-1:0]] <= tgt_reg[AW-1:0];
        end
    end

    logic          full, front;
    logic [PW-1:0] read_tgt, alloc_n, nbr;
    always_comb
    begin
        full    = free_cnt_reg == '0 && fresh_cnt_reg >= NIL;
        alloc_n = (free_cnt_reg != '0) ? PW'(free_top_reg) : fresh_cnt_reg;
        // A push links at the front for push front, or when there is no node
        // to link after (null cursor, or empty list for push back).
        front   = kind_reg == OP_PUSH_FRONT || tgt_reg == NIL;
        nbr     = (kind_reg == OP_NEXT) ? rdata.nxt : rdata.prv;
        case (kind_reg)
            OP_FIRST, OP_POP_FRONT:             read_tgt = head_reg;
            OP_LAST, OP_POP_BACK, OP_PUSH_BACK: read_tgt = tail_reg;
            default:                            read_tgt = cur_reg;
        endcase
    end

    // Memory port control. Each fix address differs from the new node and
    // from the other fix address, so no access in flight hits a stale word.
    always_comb
    begin
        raddr = read_tgt[AW-1:0];
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        case (state_reg)
            S_FIX1:
            begin
                raddr = fx1_addr_reg[AW-1:0];
                if (newn_reg != NIL)
                begin
                    we    = 1'b1;
                    waddr = newn_reg[AW-1:0];
                    wdata = node_reg;
                end
            end
            S_FIX2:
            begin
                raddr = fx2_addr_reg[AW-1:0];
                if (fx1_reg)
                begin
                    we        = 1'b1;
                    waddr     = fx1_addr_reg[AW-1:0];
                    wdata     = rdata;
                    wdata.prv = fx1_val_reg;
                end
            end
            S_FIX3:
            begin
                we        = 1'b1;
                waddr     = fx2_addr_reg[AW-1:0];
                wdata     = rdata;
                wdata.nxt = fx2_val_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cur_next       = cur_reg;
        free_cnt_next  = free_cnt_reg;
        fresh_cnt_next = fresh_cnt_reg;
        kind_next      = kind_reg;
        val_next       = val_reg;
        tgt_next       = tgt_reg;
        newn_next      = newn_reg;
        node_next      = node_reg;
        rsp_next       = rsp_reg;
        done_next      = 1'b0;
        mv_next        = mv_reg;
        fx1_next       = fx1_reg;
        fx2_next       = fx2_reg;
        fx1_addr_next  = fx1_addr_reg;
        fx1_val_next   = fx1_val_reg;
        fx2_addr_next  = fx2_addr_reg;
        fx2_val_next   = fx2_val_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next  = op_kind_t'(cmd.kind);
                    val_next   = DATA_WIDTH'(cmd.item_value);
                    mv_next    = 1'b0;
                    fx1_next   = 1'b0;
                    fx2_next   = 1'b0;
                    newn_next  = NIL;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                tgt_next   = read_tgt;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                rsp_next = '0;
                case (kind_reg)
                    OP_FIRST, OP_LAST:
                    begin
                        if (tgt_reg != NIL)
                        begin
                            cur_next              = tgt_reg;
                            rsp_next.result_value = WORD_W'(rdata.val);
                            rsp_next.found        = 1'b1;
                        end
                    end
                    OP_NEXT, OP_PREV:
                    begin
                        // The neighbor is read next; a missing one is a miss.
                        if (tgt_reg != NIL && nbr != NIL)
                        begin
                            mv_next       = 1'b1;
                            fx1_addr_next = nbr;
                        end
                    end
                    OP_PUSH_FRONT, OP_PUSH_BACK, OP_PUSH_CURRENT:
                    begin
                        if (full)
                        begin
                            rsp_next.dropped_full = 1'b1;
                        end
                        else
                        begin
                            if (free_cnt_reg != '0)
                                free_cnt_next = free_cnt_reg - PW'(1);
                            else
                                fresh_cnt_next = fresh_cnt_reg + PW'(1);
                            newn_next     = alloc_n;
                            node_next.val = val_reg;
                            if (front)
                            begin
                                node_next.prv = NIL;
                                node_next.nxt = head_reg;
                                head_next     = alloc_n;
                                if (head_reg == NIL)
                                    tail_next = alloc_n;
                                else
                                begin
                                    fx1_next      = 1'b1;
                                    fx1_addr_next = head_reg;
                                    fx1_val_next  = alloc_n;
                                end
                                // Push back on an empty list leaves the cursor
                                // at the null tail it was moved to.
                                if (kind_reg == OP_PUSH_BACK)
                                    cur_next = NIL;
                            end
                            else
                            begin
                                node_next.prv = tgt_reg;
                                node_next.nxt = rdata.nxt;
                                cur_next      = alloc_n;
                                fx2_next      = 1'b1;
                                fx2_addr_next = tgt_reg;
                                fx2_val_next  = alloc_n;
                                if (rdata.nxt == NIL)
                                    tail_next = alloc_n;
                                else
                                begin
                                    fx1_next      = 1'b1;
                                    fx1_addr_next = rdata.nxt;
                                    fx1_val_next  = alloc_n;
                                end
                            end
                        end
                    end
                    OP_POP_FRONT, OP_POP_BACK, OP_POP_CURRENT:
                    begin
                        cur_next = tgt_reg;
                        if (tgt_reg != NIL)
                        begin
                            rsp_next.result_value = WORD_W'(rdata.val);
                            rsp_next.found        = 1'b1;
                            if (free_cnt_reg < NIL)
                                free_cnt_next = free_cnt_reg + PW'(1);
                            if (head_reg == tail_reg)
                            begin
                                head_next = NIL;
                                tail_next = NIL;
                                cur_next  = NIL;
                            end
                            else if (tgt_reg == head_reg)
                            begin
                                head_next     = rdata.nxt;
                                cur_next      = rdata.nxt;
                                fx1_next      = rdata.nxt != NIL;
                                fx1_addr_next = rdata.nxt;
                                fx1_val_next  = NIL;
                            end
                            else if (tgt_reg == tail_reg)
                            begin
                                tail_next     = rdata.prv;
                                cur_next      = rdata.prv;
                                fx2_next      = rdata.prv != NIL;
                                fx2_addr_next = rdata.prv;
                                fx2_val_next  = NIL;
                            end
                            else
                            begin
                                cur_next      = rdata.nxt;
                                fx1_next      = rdata.nxt != NIL;
                                fx1_addr_next = rdata.nxt;
                                fx1_val_next  = rdata.prv;
                                fx2_next      = rdata.prv != NIL;
                                fx2_addr_next = rdata.prv;
                                fx2_val_next  = rdata.nxt;
                            end
                        end
                    end
                    OP_CLEAR:
                    begin
                        head_next      = NIL;
                        tail_next      = NIL;
                        cur_next       = NIL;
                        free_cnt_next  = '0;
                        fresh_cnt_next = '0;
                    end
                    default:
                    begin
                    end
                endcase
                // Operations with no further memory pass finish right here.
                if (mv_next || newn_next != NIL || fx1_next || fx2_next)
                    state_next = S_FIX1;
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FIX1:
            begin
                if (mv_reg || fx1_reg || fx2_reg)
                    state_next = S_FIX2;
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FIX2:
            begin
                if (mv_reg)
                begin
                    cur_next              = fx1_addr_reg;
                    rsp_next.result_value = WORD_W'(rdata.val);
                    rsp_next.found        = 1'b1;
                    done_next             = 1'b1;
                    state_next            = S_IDLE;
                end
                else if (fx2_reg)
                    state_next = S_FIX3;
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FIX3:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= NIL;
            tail_reg      <= NIL;
            cur_reg       <= NIL;
            free_cnt_reg  <= '0;
            fresh_cnt_reg <= '0;
            kind_reg      <= OP_FIRST;
            val_reg       <= '0;
            tgt_reg       <= NIL;
            newn_reg      <= NIL;
            node_reg      <= '0;
            rsp_reg       <= '0;
            done_reg      <= 1'b0;
            mv_reg        <= 1'b0;
            fx1_reg       <= 1'b0;
            fx2_reg       <= 1'b0;
            fx1_addr_reg  <= '0;
            fx1_val_reg   <= '0;
            fx2_addr_reg  <= '0;
            fx2_val_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cur_reg       <= cur_next;
            free_cnt_reg  <= free_cnt_next;
            fresh_cnt_reg <= fresh_cnt_next;
            kind_reg      <= kind_next;
            val_reg       <= val_next;
            tgt_reg       <= tgt_next;
            newn_reg      <= newn_next;
            node_reg      <= node_next;
            rsp_reg       <= rsp_next;
            done_reg      <= done_next;
            mv_reg        <= mv_next;
            fx1_reg       <= fx1_next;
            fx2_reg       <= fx2_next;
            fx1_addr_reg  <= fx1_addr_next;
            fx1_val_reg   <= fx1_val_next;
            fx2_addr_reg  <= fx2_addr_next;
            fx2_val_reg   <= fx2_val_next;
        end
    end

    // A new word may be taken in the cycle its predecessor's result is strobed.
    assign busy = state_reg != S_IDLE;
    assign done = done_reg;
    assign rsp  = rsp_reg;
endmodule

// File: hdl/dll_checker.sv
// Port-level checker for the list block, bound to the top level.
// Depends on dll_pkg.
module dll_port_checker
    import dll_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input logic      done,
    input rsp_word_t rsp
);
    a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("busy not raised after start");
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result strobe longer than one cycle");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !rsp.found) |-> rsp.result_value == '0) else $error("value without found");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(rsp.found && rsp.dropped_full)) else $error("found and dropped both set");
endmodule

bind doubly_linked_list_with_cursor_top dll_port_checker u_dll_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done), .rsp(rsp)
);
